FILE: rtl/tcp_std_pkg.sv
package tcp_std_pkg;

  localparam int unsigned MAX_SEGMENTS = 63;
  localparam int unsigned SEG_CNT_W    = $clog2(MAX_SEGMENTS + 1);
  localparam logic [16:0] BUF_BYTES    = 17'd65536;
  localparam logic [15:0] MSS_RESET    = 16'd536;

  localparam logic [1:0] KIND_SEG  = 2'd0;
  localparam logic [1:0] KIND_ACK  = 2'd1;
  localparam logic [1:0] KIND_DONE = 2'd2;

  localparam logic [3:0] ST_SYNRCVD = 4'd3;
  localparam logic [3:0] ST_ESTD    = 4'd4;
  localparam logic [3:0] ST_FIN1    = 4'd5;
  localparam logic [3:0] ST_CWAIT   = 4'd7;
  localparam logic [3:0] ST_LASTACK = 4'd9;

  typedef enum logic [14:0] {
    FSM_IDLE = 15'b000000000000001,
    FSM_OFF  = 15'b000000000000010,
    FSM_SYN  = 15'b000000000000100,
    FSM_REM  = 15'b000000000001000,
    FSM_LEN  = 15'b000000000010000,
    FSM_END  = 15'b000000000100000,
    FSM_FIN  = 15'b000000001000000,
    FSM_FIN2 = 15'b000000010000000,
    FSM_PSH1 = 15'b000000100000000,
    FSM_PSH2 = 15'b000001000000000,
    FSM_SUM  = 15'b000010000000000,
    FSM_CMP  = 15'b000100000000000,
    FSM_ADV  = 15'b001000000000000,
    FSM_SNXT = 15'b010000000000000,
    FSM_TERM = 15'b100000000000000
  } fsm_e;

endpackage

FILE: rtl/tcp_segment_transmit_decider.sv
// Channel   | Direction | Handshake                     | Payload
// request   | in        | start_i & !busy_o             | start_seq_i .. cong_window_i
// mss cfg   | in        | cfg_valid_i & cfg_ready_o     | cfg_data_i
// result    | out       | result_valid_o, one cycle     | kind_o .. last_o
//
// One shared 34-bit add/subtract unit is stepped by a one-hot sequencer.
// Each emitted segment steps the sequencer from the offset state to the
// send-next state; a closing check ends a run, or a terminal state does when
// the limit of 63 segments is hit, and busy_o is held for the whole run. Results are registered
// and strobed for one cycle; the receiver cannot stall. Reset returns the
// sequencer to idle and the segment size to 536.
module tcp_segment_transmit_decider
  import tcp_std_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [31:0] start_seq_i,
  input  logic [31:0] unacked_seq_i,
  input  logic [16:0] buffered_len_i,
  input  logic [3:0]  conn_state_i,
  input  logic [31:0] syn_seq_i,
  input  logic [31:0] fin_seq_i,
  input  logic [31:0] push_seq_i,
  input  logic        write_done_i,
  input  logic        push_ok_i,
  input  logic [31:0] send_next_i,
  input  logic [30:0] cong_window_i,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [15:0] cfg_data_i,
  output logic        result_valid_o,
  output logic [1:0]  kind_o,
  output logic [16:0] buf_offset_o,
  output logic [15:0] seg_len_o,
  output logic        syn_flag_o,
  output logic        fin_flag_o,
  output logic        psh_flag_o,
  output logic [3:0]  new_state_o,
  output logic [31:0] new_send_next_o,
  output logic        last_o
);

  fsm_e fsm_q, fsm_d;

  logic [15:0] mss_q;
  logic [31:0] seq_q, suna_q, ssyn_q, sfin_q, spush_q, snext_q;
  logic [16:0] sblen_q;
  logic [3:0]  state_q;
  logic        wrdone_q, pushok_q;
  logic [30:0] cwnd_q;

  logic [31:0] off_q, end_q;
  logic [16:0] rem_q;
  logic        inr_q;
  logic [15:0] len_q, gap_q;
  logic        syn_q, fin_q, psh_q, fin_eq_q, pl_q, zero_q;
  logic [33:0] sum_q;
  logic [SEG_CNT_W-1:0] cnt_q;

  logic        res_valid_q;
  logic [1:0]  kind_q;
  logic [16:0] offs_q;
  logic [15:0] olen_q;
  logic        osyn_q, ofin_q, opsh_q, olast_q;
  logic [3:0]  ostate_q;
  logic [31:0] osnext_q;

  logic [33:0] op_a, op_b, res;
  logic        op_sub;
  logic [16:0] total;
  logic [33:0] pipe;
  logic        accept;
  logic        state_low;
  logic [31:0] d32;

  assign accept      = start_i && !busy_o;
  assign busy_o      = (fsm_q != FSM_IDLE);
  assign cfg_ready_o = !busy_o;
  assign state_low   = (state_q <= ST_SYNRCVD);
  assign total       = {1'b0, len_q} + {16'd0, syn_q} + {16'd0, fin_q};
  assign pipe        = state_low ? 34'd0 : {{2{off_q[31]}}, off_q};
  assign d32         = res[31:0];

  // shared adder / subtractor
  always_comb begin
    op_a   = '0;
    op_b   = '0;
    op_sub = 1'b1;
    case (fsm_q)
      FSM_OFF: begin
        op_a = {2'b00, seq_q};
        op_b = {2'b00, suna_q};
      end
      FSM_SYN: begin
        op_a = {2'b00, seq_q};
        op_b = {2'b00, ssyn_q};
      end
      FSM_REM: begin
        op_a = {17'd0, sblen_q};
        op_b = {{2{off_q[31]}}, off_q};
      end
      FSM_LEN: begin
        op_a = {17'd0, rem_q};
        op_b = {18'd0, mss_q};
      end
      FSM_END: begin
        op_a   = {2'b00, seq_q};
        op_b   = {18'd0, len_q};
        op_sub = 1'b0;
      end
      FSM_FIN: begin
        op_a = {2'b00, end_q};
        op_b = {2'b00, sfin_q};
      end
      FSM_FIN2: begin
        op_a = {2'b00, snext_q};
        op_b = {2'b00, sfin_q};
      end
      FSM_PSH1: begin
        op_a = {2'b00, spush_q};
        op_b = {2'b00, seq_q};
      end
      FSM_PSH2: begin
        op_a = {2'b00, end_q};
        op_b = {2'b00, spush_q};
      end
      FSM_SUM: begin
        op_a   = pipe;
        op_b   = {17'd0, total};
        op_sub = 1'b0;
      end
      FSM_CMP: begin
        op_a = {3'b000, cwnd_q};
        op_b = sum_q;
      end
      FSM_ADV: begin
        op_a   = {2'b00, seq_q};
        op_b   = {17'd0, total};
        op_sub = 1'b0;
      end
      FSM_SNXT: begin
        op_a = {2'b00, snext_q};
        op_b = {2'b00, seq_q};
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  assign res = op_sub ? (op_a - op_b) : (op_a + op_b);

  always_comb begin
    fsm_d = fsm_q;
    case (fsm_q)
      FSM_IDLE: if (accept) fsm_d = FSM_OFF;
      FSM_OFF:  fsm_d = FSM_SYN;
      FSM_SYN:  fsm_d = FSM_REM;
      FSM_REM:  fsm_d = FSM_LEN;
      FSM_LEN:  fsm_d = FSM_END;
      FSM_END:  fsm_d = FSM_FIN;
      FSM_FIN:  fsm_d = FSM_FIN2;
      FSM_FIN2: fsm_d = FSM_PSH1;
      FSM_PSH1: fsm_d = FSM_PSH2;
      FSM_PSH2: fsm_d = FSM_SUM;
      FSM_SUM:  fsm_d = FSM_CMP;
      FSM_CMP:  fsm_d = (zero_q || res[33]) ? FSM_IDLE : FSM_ADV;
      FSM_ADV:  fsm_d = FSM_SNXT;
      FSM_SNXT: begin
        if (cnt_q == SEG_CNT_W'(MAX_SEGMENTS - 1)) begin
          fsm_d = FSM_TERM;
        end else begin
          fsm_d = FSM_OFF;
        end
      end
      FSM_TERM: fsm_d = FSM_IDLE;
      default:  fsm_d = FSM_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fsm_q       <= FSM_IDLE;
      mss_q       <= MSS_RESET;
      res_valid_q <= 1'b0;
      cnt_q       <= '0;
    end else begin
      fsm_q       <= fsm_d;
      if (cfg_valid_i && cfg_ready_o) begin
        mss_q <= cfg_data_i;
      end
      if (accept) begin
        cnt_q <= '0;
      end
      case (fsm_q)
        FSM_CMP:  res_valid_q <= zero_q || res[33];
        FSM_SNXT: begin
          res_valid_q <= 1'b1;
          cnt_q       <= cnt_q + 1'b1;
        end
        FSM_TERM: res_valid_q <= 1'b1;
        default:  res_valid_q <= 1'b0;
      endcase
    end
  end

  // datapath and result registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      seq_q    <= start_seq_i;
      suna_q   <= unacked_seq_i;
      sblen_q  <= (buffered_len_i > BUF_BYTES) ? BUF_BYTES : buffered_len_i;
      state_q  <= conn_state_i;
      ssyn_q   <= syn_seq_i;
      sfin_q   <= fin_seq_i;
      spush_q  <= push_seq_i;
      wrdone_q <= write_done_i;
      pushok_q <= push_ok_i;
      snext_q  <= send_next_i;
      cwnd_q   <= cong_window_i;
    end
    case (fsm_q)
      FSM_OFF: off_q <= d32;
      FSM_SYN: syn_q <= state_low && (d32 == 32'd0 || d32[31]);
      FSM_REM: begin
        rem_q <= res[16:0];
        inr_q <= !off_q[31] && !res[33] && (res != 34'd0);
      end
      FSM_LEN: begin
        if (!inr_q) begin
          len_q <= 16'd0;
        end else if (res[33]) begin
          len_q <= rem_q[15:0];
        end else begin
          len_q <= mss_q;
        end
      end
      FSM_END: end_q <= d32;
      FSM_FIN: fin_eq_q <= (d32 == 32'd0);
      FSM_FIN2: begin
        fin_q <= wrdone_q && fin_eq_q && (d32 == 32'd0 || d32[31]);
        if (wrdone_q && fin_eq_q && (d32 == 32'd0 || d32[31])) begin
          if (state_q == ST_ESTD || state_q == ST_SYNRCVD) begin
            state_q <= ST_FIN1;
          end else if (state_q == ST_CWAIT) begin
            state_q <= ST_LASTACK;
          end
        end
      end
      FSM_PSH1: begin
        pl_q  <= (d32 != 32'd0) && (!d32[31] || d32[30:0] == 31'd0);
        gap_q <= d32[15:0];
      end
      FSM_PSH2: begin
        psh_q <= pushok_q && pl_q && !d32[31];
        if (pushok_q && pl_q && !d32[31]) begin
          len_q <= gap_q;
        end
      end
      FSM_SUM: begin
        sum_q  <= res;
        zero_q <= (total == 17'd0);
      end
      FSM_CMP: begin
        kind_q   <= (cnt_q == '0) ? KIND_ACK : KIND_DONE;
        offs_q   <= '0;
        olen_q   <= '0;
        osyn_q   <= 1'b0;
        ofin_q   <= 1'b0;
        opsh_q   <= 1'b0;
        ostate_q <= state_q;
        osnext_q <= snext_q;
        olast_q  <= 1'b1;
      end
      FSM_ADV: seq_q <= d32;
      FSM_SNXT: begin
        if (d32[31]) begin
          snext_q <= seq_q;
        end
        kind_q   <= KIND_SEG;
        offs_q   <= off_q[16:0];
        olen_q   <= len_q;
        osyn_q   <= syn_q;
        ofin_q   <= fin_q;
        opsh_q   <= psh_q;
        ostate_q <= state_q;
        osnext_q <= d32[31] ? seq_q : snext_q;
        olast_q  <= 1'b0;
      end
      FSM_TERM: begin
        kind_q   <= KIND_DONE;
        offs_q   <= '0;
        olen_q   <= '0;
        osyn_q   <= 1'b0;
        ofin_q   <= 1'b0;
        opsh_q   <= 1'b0;
        ostate_q <= state_q;
        osnext_q <= snext_q;
        olast_q  <= 1'b1;
      end
      default: begin
      end
    endcase
  end

  assign result_valid_o  = res_valid_q;
  assign kind_o          = kind_q;
  assign buf_offset_o    = offs_q;
  assign seg_len_o       = olen_q;
  assign syn_flag_o      = osyn_q;
  assign fin_flag_o      = ofin_q;
  assign psh_flag_o      = opsh_q;
  assign new_state_o     = ostate_q;
  assign new_send_next_o = osnext_q;
  assign last_o          = olast_q;

  // terminal transaction always closes the run
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && last_o |-> !busy_o && kind_o != KIND_SEG)
    else $error("terminal result while busy or with segment kind");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && !last_o |-> busy_o && kind_o == KIND_SEG)
    else $error("segment result outside a run");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> busy_o && cnt_q == '0)
    else $error("request not taken up");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= SEG_CNT_W'(MAX_SEGMENTS))
    else $error("segment count overflow");

endmodule

FILE: tb/sv/tcp_segment_transmit_decider_tb.sv
`timescale 1ns / 100ps

module tcp_segment_transmit_decider_tb;
  import tcp_std_pkg::*;

  localparam logic [3:0] ST_CLOSED  = 4'd0;
  localparam logic [3:0] ST_SYNSENT = 4'd2;
  localparam logic [3:0] ST_CODE_11 = 4'd11;
  localparam logic [3:0] ST_CODE_15 = 4'd15;
  localparam int WATCHDOG_LIMIT = 3000;

  typedef struct {
    logic [31:0] start_seq;
    logic [31:0] unacked_seq;
    logic [16:0] buffered_len;
    logic [3:0]  conn_state;
    logic [31:0] syn_seq;
    logic [31:0] fin_seq;
    logic [31:0] push_seq;
    logic        write_done;
    logic        push_ok;
    logic [31:0] send_next;
    logic [30:0] cong_window;
  } tx_request_t;

  typedef struct {
    logic [1:0]  kind;
    logic [16:0] buf_offset;
    logic [15:0] seg_len;
    logic        syn_flag;
    logic        fin_flag;
    logic        psh_flag;
    logic [3:0]  new_state;
    logic [31:0] new_send_next;
    logic        last;
  } tx_segment_t;

  logic        clk_i;
  logic        rst_ni;
  logic        start_i;
  logic        busy_o;
  logic [31:0] start_seq_i;
  logic [31:0] unacked_seq_i;
  logic [16:0] buffered_len_i;
  logic [3:0]  conn_state_i;
  logic [31:0] syn_seq_i;
  logic [31:0] fin_seq_i;
  logic [31:0] push_seq_i;
  logic        write_done_i;
  logic        push_ok_i;
  logic [31:0] send_next_i;
  logic [30:0] cong_window_i;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [15:0] cfg_data_i;
  logic        result_valid_o;
  logic [1:0]  kind_o;
  logic [16:0] buf_offset_o;
  logic [15:0] seg_len_o;
  logic        syn_flag_o;
  logic        fin_flag_o;
  logic        psh_flag_o;
  logic [3:0]  new_state_o;
  logic [31:0] new_send_next_o;
  logic        last_o;

  tcp_segment_transmit_decider dut (.*);

  tx_segment_t expected_segments[$];
  logic [15:0] mss_setting = MSS_RESET;
  int sender_idle_pct = 8;
  int mismatches = 0;
  int requests_sent = 0;
  int segments_seen = 0;
  int acks_seen = 0;
  int dones_seen = 0;
  int idle_cycles = 0;

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // ---------------- segmentation predictor ----------------

  function automatic logic seq_before(logic [31:0] a, logic [31:0] b);
    logic [31:0] d;
    d = a - b;
    return d[31];
  endfunction

  function automatic void push_segment(logic [1:0] kind, logic [16:0] offs,
                                       logic [15:0] len, logic syn, logic fin,
                                       logic psh, logic [3:0] st,
                                       logic [31:0] snext, logic last);
    tx_segment_t r;
    r.kind          = kind;
    r.buf_offset    = offs;
    r.seg_len       = len;
    r.syn_flag      = syn;
    r.fin_flag      = fin;
    r.psh_flag      = psh;
    r.new_state     = st;
    r.new_send_next = snext;
    r.last          = last;
    expected_segments.push_back(r);
  endfunction

  function automatic void predict_segments(tx_request_t rq);
    logic [31:0] seq;
    logic [31:0] snext;
    logic [31:0] seg_end;
    logic [31:0] gap;
    logic [3:0]  st;
    longint      off;
    longint      sblen;
    longint      pipe;
    int unsigned len;
    int unsigned cnt;
    logic        syn;
    logic        fin;
    logic        psh;
    seq   = rq.start_seq;
    snext = rq.send_next;
    st    = rq.conn_state;
    sblen = (rq.buffered_len > BUF_BYTES) ? longint'(BUF_BYTES) : longint'(rq.buffered_len);
    for (int n = 0; n < MAX_SEGMENTS; n++) begin
      off = $signed(seq - rq.unacked_seq);
      len = 0;
      cnt = 0;
      syn = 1'b0;
      fin = 1'b0;
      psh = 1'b0;
      if (off >= 0 && off < sblen) begin
        len = (sblen - off < longint'(mss_setting)) ? int'(sblen - off) : mss_setting;
      end
      if (st <= ST_SYNRCVD && (seq == rq.syn_seq || seq_before(seq, rq.syn_seq))) begin
        syn = 1'b1;
        cnt++;
      end
      seg_end = seq + len;
      if (rq.write_done && seg_end == rq.fin_seq &&
          (snext == rq.fin_seq || seq_before(snext, rq.fin_seq))) begin
        fin = 1'b1;
        cnt++;
        if (st == ST_ESTD || st == ST_SYNRCVD) begin
          st = ST_FIN1;
        end else if (st == ST_CWAIT) begin
          st = ST_LASTACK;
        end
      end
      if (rq.push_ok && seq_before(seq, rq.push_seq) && !seq_before(seg_end, rq.push_seq)) begin
        gap = rq.push_seq - seq;
        if (gap < len) len = gap;
        psh = 1'b1;
      end
      pipe = (st <= ST_SYNRCVD) ? 0 : off;
      if (len + cnt == 0 ||
          pipe + longint'(len) + longint'(cnt) > longint'(rq.cong_window)) begin
        push_segment((n == 0) ? KIND_ACK : KIND_DONE, '0, '0, 1'b0, 1'b0, 1'b0,
                     st, snext, 1'b1);
        return;
      end
      seq = seq + len + cnt;
      if (seq_before(snext, seq)) snext = seq;
      push_segment(KIND_SEG, off[16:0], len[15:0], syn, fin, psh, st, snext, 1'b0);
    end
    push_segment(KIND_DONE, '0, '0, 1'b0, 1'b0, 1'b0, st, snext, 1'b1);
  endfunction

  // ---------------- result checking ----------------

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk_i) begin
    tx_segment_t want;
    if (rst_ni && result_valid_o) begin
      if (kind_o == KIND_SEG) segments_seen++;
      else if (kind_o == KIND_ACK) acks_seen++;
      else dones_seen++;
      if (expected_segments.size() == 0) begin
        $error("result with no transaction outstanding (kind %0d)", kind_o);
        mismatches++;
      end else begin
        want = expected_segments.pop_front();
        check_field("kind", 32'(want.kind), 32'(kind_o));
        check_field("buf_offset", 32'(want.buf_offset), 32'(buf_offset_o));
        check_field("seg_len", 32'(want.seg_len), 32'(seg_len_o));
        check_field("syn_flag", 32'(want.syn_flag), 32'(syn_flag_o));
        check_field("fin_flag", 32'(want.fin_flag), 32'(fin_flag_o));
        check_field("psh_flag", 32'(want.psh_flag), 32'(psh_flag_o));
        check_field("new_state", 32'(want.new_state), 32'(new_state_o));
        check_field("new_send_next", want.new_send_next, new_send_next_o);
        check_field("last", 32'(want.last), 32'(last_o));
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (start_i && !busy_o) || result_valid_o || (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
      $display("FAILURE");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // ---------------- drivers ----------------

  task automatic send_request(tx_request_t rq);
    while ($urandom_range(99) < sender_idle_pct) begin
      start_i <= 1'b0;
      @(posedge clk_i);
    end
    start_i        <= 1'b1;
    start_seq_i    <= rq.start_seq;
    unacked_seq_i  <= rq.unacked_seq;
    buffered_len_i <= rq.buffered_len;
    conn_state_i   <= rq.conn_state;
    syn_seq_i      <= rq.syn_seq;
    fin_seq_i      <= rq.fin_seq;
    push_seq_i     <= rq.push_seq;
    write_done_i   <= rq.write_done;
    push_ok_i      <= rq.push_ok;
    send_next_i    <= rq.send_next;
    cong_window_i  <= rq.cong_window;
    do @(posedge clk_i); while (busy_o);
    predict_segments(rq);
    requests_sent++;
  endtask

  task automatic drain_results();
    start_i <= 1'b0;
    do @(posedge clk_i); while (expected_segments.size() != 0);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_segment_size(logic [15:0] value);
    drain_results();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    mss_setting = value;
  endtask

  // ---------------- stimulus ----------------

  function automatic tx_request_t base_request();
    tx_request_t rq;
    rq.unacked_seq  = 32'h1000_0000;
    rq.start_seq    = rq.unacked_seq;
    rq.buffered_len = 17'd100;
    rq.conn_state   = ST_ESTD;
    rq.syn_seq      = rq.start_seq - 32'd1;
    rq.fin_seq      = rq.start_seq + 32'd5000;
    rq.push_seq     = rq.start_seq;
    rq.write_done   = 1'b0;
    rq.push_ok      = 1'b0;
    rq.send_next    = rq.start_seq;
    rq.cong_window  = 31'd65535;
    return rq;
  endfunction

  function automatic tx_request_t random_request();
    tx_request_t rq;
    int unsigned span;
    int unsigned blen;
    if ($urandom_range(99) < 20) begin
      rq.start_seq    = $urandom;
      rq.unacked_seq  = $urandom;
      rq.buffered_len = 17'($urandom);
      rq.conn_state   = 4'($urandom);
      rq.syn_seq      = $urandom;
      rq.fin_seq      = $urandom;
      rq.push_seq     = $urandom;
      rq.write_done   = 1'($urandom);
      rq.push_ok      = 1'($urandom);
      rq.send_next    = $urandom;
      rq.cong_window  = 31'($urandom);
      return rq;
    end
    span = 3 * mss_setting + 8;
    if (span > 131071) span = 131071;
    case ($urandom_range(9))
      0:       blen = $urandom_range(0, 131071);
      1, 2:    blen = $urandom_range(0, 64);
      default: blen = $urandom_range(0, span);
    endcase
    rq.unacked_seq  = $urandom;
    rq.buffered_len = 17'(blen);
    case ($urandom_range(9))
      0, 1, 2, 3, 4: rq.start_seq = rq.unacked_seq;
      9:             rq.start_seq = rq.unacked_seq - $urandom_range(1, 8);
      default:       rq.start_seq = rq.unacked_seq + $urandom_range(0, blen);
    endcase
    case ($urandom_range(19))
      0, 1, 2, 3, 4, 5, 6, 7, 8, 9: rq.conn_state = ST_ESTD;
      10, 11, 12:                   rq.conn_state = ST_CWAIT;
      13, 14:                       rq.conn_state = ST_SYNRCVD;
      default:                      rq.conn_state = 4'($urandom_range(0, 15));
    endcase
    rq.syn_seq = rq.start_seq + $urandom_range(0, 2) - 32'd1;
    if ($urandom_range(1)) begin
      rq.fin_seq = rq.unacked_seq + ((blen > 65536) ? 65536 : blen);
    end else begin
      rq.fin_seq = rq.unacked_seq + $urandom_range(0, blen + 2);
    end
    rq.push_seq   = rq.unacked_seq + $urandom_range(0, blen + 1);
    rq.write_done = 1'($urandom_range(1));
    rq.push_ok    = 1'($urandom_range(1));
    rq.send_next  = rq.start_seq + $urandom_range(0, 4) - 32'd2;
    case ($urandom_range(19))
      0, 1, 2, 3, 4, 5, 6, 7: rq.cong_window = 31'($urandom);
      8, 9, 10, 11, 12, 13:   rq.cong_window = 31'($urandom_range(0, 4 * mss_setting + 4));
      14, 15, 16:             rq.cong_window = 31'h7fff_ffff;
      default:                rq.cong_window = 31'($urandom_range(0, 3));
    endcase
    return rq;
  endfunction

  task automatic run_random_traffic(int count, bit pause_midway);
    for (int i = 0; i < count; i++) begin
      if (pause_midway && i == count / 2) drain_results();
      send_request(random_request());
    end
  endtask

  // ---------------- tests ----------------

  task automatic test_reset_segment_size();
    tx_request_t rq;
    rq = base_request();
    rq.buffered_len = 17'd1500;
    send_request(rq);
    rq = base_request();
    send_request(rq);
  endtask

  task automatic test_special_cases();
    tx_request_t rq;
    rq = base_request();
    rq.buffered_len = 17'd0;
    send_request(rq);
    rq = base_request();
    rq.buffered_len = 17'h1ffff;
    rq.cong_window  = 31'h7fff_ffff;
    send_request(rq);
    rq = base_request();
    rq.start_seq = rq.unacked_seq - 32'd3;
    send_request(rq);
    rq = base_request();
    rq.cong_window = 31'd0;
    send_request(rq);
    rq = base_request();
    rq.cong_window = 31'd100;
    send_request(rq);
    rq.cong_window = 31'd99;
    send_request(rq);
    rq = base_request();
    rq.conn_state   = ST_SYNSENT;
    rq.buffered_len = 17'd0;
    rq.syn_seq      = rq.start_seq;
    send_request(rq);
    rq = base_request();
    rq.conn_state = ST_CLOSED;
    rq.syn_seq    = rq.start_seq;
    rq.buffered_len = 17'd10;
    send_request(rq);
    rq = base_request();
    rq.write_done = 1'b1;
    rq.fin_seq    = rq.start_seq + 32'd100;
    send_request(rq);
    rq.conn_state = ST_SYNRCVD;
    send_request(rq);
    rq.conn_state = ST_CWAIT;
    send_request(rq);
    rq.send_next = rq.fin_seq + 32'd1;
    send_request(rq);
    rq = base_request();
    rq.buffered_len = 17'd0;
    rq.write_done   = 1'b1;
    rq.fin_seq      = rq.start_seq;
    rq.cong_window  = 31'd0;
    send_request(rq);
    rq = base_request();
    rq.write_done = 1'b1;
    rq.fin_seq    = rq.start_seq + 32'd100;
    rq.push_ok    = 1'b1;
    rq.push_seq   = rq.start_seq + 32'd40;
    send_request(rq);
    rq = base_request();
    rq.push_ok  = 1'b1;
    rq.push_seq = rq.start_seq + 32'd30;
    send_request(rq);
    rq = base_request();
    rq.conn_state = ST_CODE_15;
    rq.syn_seq    = rq.start_seq + 32'd10;
    rq.write_done = 1'b1;
    rq.fin_seq    = rq.start_seq + 32'd100;
    send_request(rq);
    rq.conn_state = ST_CODE_11;
    send_request(rq);
    rq = base_request();
    rq.conn_state  = ST_LASTACK;
    rq.start_seq   = rq.unacked_seq + 32'd60;
    rq.cong_window = 31'd80;
    send_request(rq);
    rq = base_request();
    rq.unacked_seq = 32'hffff_fff0;
    rq.start_seq   = rq.unacked_seq;
    rq.send_next   = rq.start_seq;
    rq.write_done  = 1'b1;
    rq.fin_seq     = rq.start_seq + 32'd100;
    send_request(rq);
    rq.start_seq    = '1;
    rq.unacked_seq  = '1;
    rq.buffered_len = '1;
    rq.conn_state   = '1;
    rq.syn_seq      = '1;
    rq.fin_seq      = '1;
    rq.push_seq     = '1;
    rq.write_done   = 1'b1;
    rq.push_ok      = 1'b1;
    rq.send_next    = '1;
    rq.cong_window  = '1;
    send_request(rq);
    rq.start_seq    = '0;
    rq.unacked_seq  = '0;
    rq.buffered_len = '0;
    rq.conn_state   = '0;
    rq.syn_seq      = '0;
    rq.fin_seq      = '0;
    rq.push_seq     = '0;
    rq.write_done   = 1'b0;
    rq.push_ok      = 1'b0;
    rq.send_next    = '0;
    rq.cong_window  = '0;
    send_request(rq);
  endtask

  task automatic test_segment_size_sweep();
    tx_request_t rq;
    logic [15:0] sizes[3] = '{16'd0, 16'd1, 16'hffff};
    foreach (sizes[k]) begin
      write_segment_size(sizes[k]);
      rq = base_request();
      rq.conn_state = ST_SYNRCVD;
      rq.syn_seq    = rq.start_seq;
      rq.write_done = 1'b1;
      rq.fin_seq    = rq.start_seq + ((sizes[k] == 0) ? 32'd1 : 32'd101);
      send_request(rq);
      run_random_traffic(10, 1'b0);
    end
  endtask

  task automatic test_random_traffic();
    write_segment_size(16'($urandom_range(1, 1500)));
    sender_idle_pct = 8;
    run_random_traffic(130, 1'b1);
    write_segment_size(16'($urandom_range(1, 65535)));
    sender_idle_pct = 49;
    run_random_traffic(130, 1'b0);
    write_segment_size(MSS_RESET);
    sender_idle_pct = 0;
    run_random_traffic(130, 1'b0);
  endtask

  initial begin
    rst_ni         <= 1'b0;
    start_i        <= 1'b0;
    start_seq_i    <= '0;
    unacked_seq_i  <= '0;
    buffered_len_i <= '0;
    conn_state_i   <= '0;
    syn_seq_i      <= '0;
    fin_seq_i      <= '0;
    push_seq_i     <= '0;
    write_done_i   <= 1'b0;
    push_ok_i      <= 1'b0;
    send_next_i    <= '0;
    cong_window_i  <= '0;
    cfg_valid_i    <= 1'b0;
    cfg_data_i     <= '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_segment_size();
    test_special_cases();
    test_segment_size_sweep();
    test_random_traffic();

    drain_results();
    repeat (20) @(posedge clk_i);
    $display("%0d transmit requests at segment sizes 0, 1, 536, 65535 and random values",
             requests_sent);
    $display("results checked: %0d segments, %0d pure ACKs, %0d done; %0d mismatches",
             segments_seen, acks_seen, dones_seen, mismatches);
    if (mismatches == 0 && expected_segments.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
